// ===== rtl/qbe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package qbe_pkg;

  localparam int ISQ_STEPS = 29;
  localparam int CORDIC_STEPS = 32;

  localparam logic signed [33:0] ONE_Q28 = 34'sd268435456;
  localparam logic signed [32:0] TURN_EIGHTH = 33'sd536870912;
  localparam logic signed [32:0] TURN_QUARTER = 33'sd1073741824;
  localparam logic signed [32:0] TURN_HALF = 33'sd2147483648;
  localparam logic signed [31:0] OCTANT_MAX = 32'sd536870911;

  // binary-angle arctangent of 2^-i, 2^32 per turn
  localparam logic signed [31:0] ATAN_STEP [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
    32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772,
    32'sd166886, 32'sd83443, 32'sd41722, 32'sd20861,
    32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304,
    32'sd652, 32'sd326, 32'sd163, 32'sd81,
    32'sd41, 32'sd20, 32'sd10, 32'sd5,
    32'sd3, 32'sd1, 32'sd1, 32'sd0
  };

  typedef logic signed [33:0] wide_t;

  // roll and yaw operands and the pitch argument riding along while the square root runs
  typedef struct packed {
    wide_t roll_num;
    wide_t roll_den;
    wide_t yaw_num;
    wide_t yaw_den;
    logic signed [29:0] arg;
  } carry_t;

  typedef struct packed {
    logic [57:0] rem;
    logic [57:0] root;
    carry_t      c;
  } isq_t;

  typedef struct packed {
    logic signed [55:0] x;
    logic signed [55:0] y;
    logic signed [31:0] z;
    logic swapped;
    logic xneg;
    logic yneg;
    logic zero;
    logic diag;
  } lane_t;

  // fold (x, y) into the first octant and scale up for the cordic
  function automatic lane_t prep(wide_t y, wide_t x);
    logic [32:0] ax;
    logic [32:0] ay;
    logic [32:0] mx;
    logic [32:0] mn;
    lane_t l;
    ax = x[33] ? 33'(-x) : x[32:0];
    ay = y[33] ? 33'(-y) : y[32:0];
    l.swapped = ay > ax;
    mx = l.swapped ? ay : ax;
    mn = l.swapped ? ax : ay;
    l.xneg = x[33];
    l.yneg = y[33];
    l.zero = mn == 33'd0;
    l.diag = mn == mx;
    l.x = 56'({mx, 20'd0});
    l.y = 56'({mn, 20'd0});
    l.z = '0;
    return l;
  endfunction

  // octant angle back to a full binary angle in (-2^31, 2^31]
  function automatic logic signed [32:0] unfold(lane_t l);
    logic signed [32:0] t;
    if (l.zero) t = '0;
    else if (l.diag) t = TURN_EIGHTH;
    else if (l.z < 32'sd1) t = 33'sd1;
    else if (l.z > OCTANT_MAX) t = 33'(OCTANT_MAX);
    else t = 33'(l.z);
    if (l.swapped) t = TURN_QUARTER - t;
    if (l.xneg) t = TURN_HALF - t;
    if (l.yneg) t = -t;
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/qbe_isqrt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module qbe_isqrt_cell #(
  parameter int STEP = 0
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire qbe_pkg::isq_t d,
  output qbe_pkg::isq_t      q
);

  localparam logic [57:0] BIT = 58'(1) << (56 - 2 * STEP);

  logic [57:0] trial;
  qbe_pkg::isq_t n;

  always_comb begin
    n = d;
    trial = d.root + BIT;
    if (d.rem >= trial) begin
      n.rem = d.rem - trial;
      n.root = (d.root >> 1) + BIT;
    end else begin
      n.root = d.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= n;
  end

endmodule
`default_nettype wire

// ===== rtl/qbe_cordic_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module qbe_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire qbe_pkg::lane_t d,
  output qbe_pkg::lane_t      q
);

  logic signed [55:0] dx;
  logic signed [55:0] dy;
  qbe_pkg::lane_t n;

  always_comb begin
    n = d;
    dx = d.y >>> STEP;
    dy = d.x >>> STEP;
    if (d.y > 56'sd0) begin
      n.x = d.x + dx;
      n.y = d.y - dy;
      n.z = d.z + qbe_pkg::ATAN_STEP[STEP];
    end else begin
      n.x = d.x - dx;
      n.y = d.y + dy;
      n.z = d.z - qbe_pkg::ATAN_STEP[STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= n;
  end

endmodule
`default_nettype wire

// ===== rtl/quaternion_to_binned_euler_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// pipeline: 4 product/root prep stages, 29 square-root cells, 1 fold stage, 32 cordic
//   cells, 1 unfold stage and 1 output register lie between an accepted beat and out_valid
// throughput: one beat per cycle while the skid entry is empty, every stage is a fully pipelined cell
// a two-entry output (register plus skid) keeps in_ready high while one result waits
// reset: synchronous rst clears all valid bits; payload registers are not reset
module quaternion_to_binned_euler_unit #(
  parameter int SECTORS = 18
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] quat_w,
  input  wire logic signed [15:0] quat_x,
  input  wire logic signed [15:0] quat_y,
  input  wire logic signed [15:0] quat_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [4:0]              roll_bin,
  output logic [4:0]              pitch_bin,
  output logic [4:0]              yaw_bin
);

  localparam int NI = qbe_pkg::ISQ_STEPS;
  localparam int NC = qbe_pkg::CORDIC_STEPS;
  localparam logic [5:0] SEC = 6'(SECTORS);

  // whole pipe moves together unless the skid entry is occupied
  logic en;
  logic skid_valid;
  assign en = !skid_valid;
  assign in_ready = en;

  // stage 1: the nine products, exact Q4.28
  logic prod_v;
  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wy, p_zx, p_wz, p_xy, p_zz;

  always_ff @(posedge clk) begin
    if (rst) prod_v <= 1'b0;
    else if (en) prod_v <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= 32'(quat_w) * 32'(quat_x);
      p_yz <= 32'(quat_y) * 32'(quat_z);
      p_xx <= 32'(quat_x) * 32'(quat_x);
      p_yy <= 32'(quat_y) * 32'(quat_y);
      p_wy <= 32'(quat_w) * 32'(quat_y);
      p_zx <= 32'(quat_z) * 32'(quat_x);
      p_wz <= 32'(quat_w) * 32'(quat_z);
      p_xy <= 32'(quat_x) * 32'(quat_y);
      p_zz <= 32'(quat_z) * 32'(quat_z);
    end
  end

  // stage 2: numerators, denominators and the clamped asin argument
  logic sum_v;
  qbe_pkg::carry_t sum_c;
  logic [28:0] arg_mag;
  qbe_pkg::carry_t sum_n;
  qbe_pkg::wide_t arg_full;
  logic signed [29:0] arg_cl;

  always_comb begin
    sum_n.roll_num = (34'(p_wx) + 34'(p_yz)) <<< 1;
    sum_n.roll_den = qbe_pkg::ONE_Q28 - ((34'(p_xx) + 34'(p_yy)) <<< 1);
    sum_n.yaw_num = (34'(p_wz) + 34'(p_xy)) <<< 1;
    sum_n.yaw_den = qbe_pkg::ONE_Q28 - ((34'(p_yy) + 34'(p_zz)) <<< 1);
    arg_full = (34'(p_wy) - 34'(p_zx)) <<< 1;
    if (arg_full > qbe_pkg::ONE_Q28) arg_cl = 30'(qbe_pkg::ONE_Q28);
    else if (arg_full < -qbe_pkg::ONE_Q28) arg_cl = 30'(-qbe_pkg::ONE_Q28);
    else arg_cl = arg_full[29:0];
    sum_n.arg = arg_cl;
  end

  always_ff @(posedge clk) begin
    if (rst) sum_v <= 1'b0;
    else if (en) sum_v <= prod_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_c <= sum_n;
      arg_mag <= arg_cl[29] ? 29'(-arg_cl) : arg_cl[28:0];
    end
  end

  // stage 3: arg squared as three narrow partial products
  logic pp_v;
  qbe_pkg::carry_t pp_c;
  logic [27:0] pp_hh;
  logic [28:0] pp_hl;
  logic [29:0] pp_ll;

  always_ff @(posedge clk) begin
    if (rst) pp_v <= 1'b0;
    else if (en) pp_v <= sum_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_c <= sum_c;
      pp_hh <= 28'(arg_mag[28:15]) * 28'(arg_mag[28:15]);
      pp_hl <= 29'(arg_mag[28:15]) * 29'(arg_mag[14:0]);
      pp_ll <= 30'(arg_mag[14:0]) * 30'(arg_mag[14:0]);
    end
  end

  // stage 4: radicand 1 - arg^2 in Q2.56, start of the square-root row
  logic [NI:0] isq_v;
  qbe_pkg::isq_t isq [NI+1];
  qbe_pkg::isq_t isq_head;
  logic [57:0] sq;

  assign sq = (58'(pp_hh) << 30) + (58'(pp_hl) << 16) + 58'(pp_ll);
  assign isq[0] = isq_head;

  always_ff @(posedge clk) begin
    if (rst) isq_v <= '0;
    else if (en) isq_v <= {isq_v[NI-1:0], pp_v};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      isq_head.rem <= (58'(1) << 56) - sq;
      isq_head.root <= '0;
      isq_head.c <= pp_c;
    end
  end

  // square-root row, one result bit per cell
  for (genvar k = 0; k < NI; k++) begin : g_isq
    qbe_isqrt_cell #(.STEP(k)) u_cell (
      .clk(clk),
      .en (en),
      .d  (isq[k]),
      .q  (isq[k+1])
    );
  end

  // fold stage feeds three cordic rows: roll, pitch, yaw
  logic [NC:0] cor_v;
  qbe_pkg::lane_t roll_l [NC+1];
  qbe_pkg::lane_t pitch_l [NC+1];
  qbe_pkg::lane_t yaw_l [NC+1];
  qbe_pkg::lane_t roll_head, pitch_head, yaw_head;

  assign roll_l[0] = roll_head;
  assign pitch_l[0] = pitch_head;
  assign yaw_l[0] = yaw_head;

  always_ff @(posedge clk) begin
    if (rst) cor_v <= '0;
    else if (en) cor_v <= {cor_v[NC-1:0], isq_v[NI]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_head <= qbe_pkg::prep(isq[NI].c.roll_num, isq[NI].c.roll_den);
      pitch_head <= qbe_pkg::prep(34'(isq[NI].c.arg), 34'(isq[NI].root[28:0]));
      yaw_head <= qbe_pkg::prep(isq[NI].c.yaw_num, isq[NI].c.yaw_den);
    end
  end

  for (genvar i = 0; i < NC; i++) begin : g_cor
    qbe_cordic_cell #(.STEP(i)) u_roll (
      .clk(clk), .en(en), .d(roll_l[i]), .q(roll_l[i+1])
    );
    qbe_cordic_cell #(.STEP(i)) u_pitch (
      .clk(clk), .en(en), .d(pitch_l[i]), .q(pitch_l[i+1])
    );
    qbe_cordic_cell #(.STEP(i)) u_yaw (
      .clk(clk), .en(en), .d(yaw_l[i]), .q(yaw_l[i+1])
    );
  end

  // unfold the octant angles into signed binary angles
  logic fin_v;
  logic signed [32:0] roll_t, pitch_t, yaw_t;

  always_ff @(posedge clk) begin
    if (rst) fin_v <= 1'b0;
    else if (en) fin_v <= cor_v[NC];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_t <= qbe_pkg::unfold(roll_l[NC]);
      pitch_t <= qbe_pkg::unfold(pitch_l[NC]);
      yaw_t <= qbe_pkg::unfold(yaw_l[NC]);
    end
  end

  // sector index: offset to zero, scale by the sector count, keep the top bits
  logic [32:0] roll_u, pitch_u, yaw_u;
  logic [38:0] roll_p, pitch_p, yaw_p;
  logic [4:0] roll_c, pitch_c, yaw_c;

  always_comb begin
    roll_u = 33'(roll_t + qbe_pkg::TURN_HALF);
    pitch_u = 33'(pitch_t + qbe_pkg::TURN_QUARTER);
    yaw_u = 33'(yaw_t + qbe_pkg::TURN_HALF);
    roll_p = 39'(roll_u) * 39'(SEC);
    pitch_p = 39'(pitch_u) * 39'(SEC);
    yaw_p = 39'(yaw_u) * 39'(SEC);
    roll_c = roll_p[36:32];
    pitch_c = pitch_p[35:31];
    yaw_c = yaw_p[36:32];
  end

  // output register with one skid entry behind it
  logic [4:0] skid_roll, skid_pitch, skid_yaw;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= fin_v;
      end
    end else if (fin_v && en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        roll_bin <= skid_roll;
        pitch_bin <= skid_pitch;
        yaw_bin <= skid_yaw;
      end else begin
        roll_bin <= roll_c;
        pitch_bin <= pitch_c;
        yaw_bin <= yaw_c;
      end
    end else if (fin_v && en) begin
      skid_roll <= roll_c;
      skid_pitch <= pitch_c;
      skid_yaw <= yaw_c;
    end
  end

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  // one expected set of sector indices per accepted quaternion
  typedef struct {
    logic [4:0] roll;
    logic [4:0] pitch;
    logic [4:0] yaw;
  } bins_t;

  localparam longint Q28 = 64'sd1 << 28;
  localparam longint EIGHTH = 64'sd1 << 29;
  localparam longint QUARTER = 64'sd1 << 30;
  localparam longint HALF = 64'sd1 << 31;
  localparam longint NSECT = 18;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] quat_w = '0;
  logic signed [15:0] quat_x = '0;
  logic signed [15:0] quat_y = '0;
  logic signed [15:0] quat_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [4:0] roll_bin;
  logic [4:0] pitch_bin;
  logic [4:0] yaw_bin;

  bins_t expected_bins[$];
  int errors = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  longint arctan_lut [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1, 0
  };

  quaternion_to_binned_euler_unit #(.SECTORS(18)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .roll_bin(roll_bin), .pitch_bin(pitch_bin), .yaw_bin(yaw_bin)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // integer square root, bit by bit
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // first-octant angle of (x, y), 0 < y < x, kept strictly inside the octant
  function automatic longint octant_angle(longint x, longint y);
    longint a;
    longint dx;
    longint dy;
    a = 0;
    x = x * (64'sd1 << 20);
    y = y * (64'sd1 << 20);
    for (int i = 0; i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        a = a + arctan_lut[i];
      end else begin
        x = x - dx;
        y = y + dy;
        a = a - arctan_lut[i];
      end
    end
    if (a < 1) a = 1;
    if (a > EIGHTH - 1) a = EIGHTH - 1;
    return a;
  endfunction

  // atan2 as a binary angle, 2^32 per turn
  function automatic longint angle_of(longint y, longint x);
    longint ax;
    longint ay;
    longint tmp;
    longint a;
    bit swp;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    swp = 0;
    if (ay > ax) begin
      tmp = ax;
      ax = ay;
      ay = tmp;
      swp = 1;
    end
    if (ay == 0) a = 0;
    else if (ay == ax) a = EIGHTH;
    else a = octant_angle(ax, ay);
    if (swp) a = QUARTER - a;
    if (x < 0) a = HALF - a;
    if (y < 0) a = -a;
    return a;
  endfunction

  function automatic logic [4:0] turn_sector(longint a);
    longint unsigned u;
    u = longint'(a + HALF);
    return 5'(((u * NSECT) >> 32) & 64'h1f);
  endfunction

  function automatic bins_t predict_bins(longint w, longint x, longint y, longint z);
    bins_t r;
    longint num;
    longint den;
    longint arg;
    longint unsigned c;
    longint unsigned u;
    num = 2 * (w * x + y * z);
    den = Q28 - 2 * (x * x + y * y);
    r.roll = turn_sector(angle_of(num, den));
    arg = 2 * (w * y - z * x);
    if (arg > Q28) arg = Q28;
    if (arg < -Q28) arg = -Q28;
    c = int_sqrt(longint'(Q28 * Q28) - longint'(arg * arg));
    u = longint'(angle_of(arg, longint'(c)) + QUARTER);
    r.pitch = 5'(((u * NSECT) >> 31) & 64'h1f);
    num = 2 * (w * z + x * y);
    den = Q28 - 2 * (y * y + z * z);
    r.yaw = turn_sector(angle_of(num, den));
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    bins_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_bins.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        e = expected_bins.pop_front();
        if (roll_bin !== e.roll) report_mismatch("roll_bin", roll_bin, e.roll);
        if (pitch_bin !== e.pitch) report_mismatch("pitch_bin", pitch_bin, e.pitch);
        if (yaw_bin !== e.yaw) report_mismatch("yaw_bin", yaw_bin, e.yaw);
      end
    end
  end

  // one quaternion beat, then idle cycles drawn one at a time
  task automatic send_quat(int w, int x, int y, int z);
    quat_w <= 16'(w);
    quat_x <= 16'(x);
    quat_y <= 16'(y);
    quat_z <= 16'(z);
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_bins.push_back(predict_bins(longint'($signed(16'(w))),
      longint'($signed(16'(x))), longint'($signed(16'(y))), longint'($signed(16'(z)))));
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic test_extremes();
    send_quat(-32768, -32768, -32768, -32768);
    send_quat(32767, 32767, 32767, 32767);
    send_quat(0, 0, 0, 0);
    send_quat(16384, 0, 0, 0);
    send_quat(-32768, 32767, -32768, 32767);
    send_quat(32767, 0, -32768, 0);
    send_quat(0, -32768, 0, 32767);
  endtask

  task automatic test_special_angles();
    send_quat(0, 16384, 0, 0);        // roll exactly +pi
    send_quat(0, 0, 0, 16384);        // yaw exactly +pi
    send_quat(16384, 0, 8192, 0);     // pitch argument exactly +1
    send_quat(16384, 0, -8192, 0);    // pitch argument exactly -1
    send_quat(16384, 0, 16384, 0);    // pitch argument clamped high
    send_quat(-16384, 0, 16384, 0);   // pitch argument clamped low
    send_quat(0, 8192, 8192, 0);      // roll with both atan2 operands zero
    send_quat(0, 0, 8192, 8192);      // yaw with both operands zero
    send_quat(11585, 11585, 0, 0);    // roll near +pi/2, zero denominator region
    send_quat(8192, 8192, 0, 0);      // equal magnitudes, diagonal angle
    send_quat(8192, -8192, 0, 0);     // negative diagonal
    send_quat(8192, 0, 0, -8192);     // yaw diagonal negative
    send_quat(8192, 8192, 8192, 8192); // all components equal, pitch argument zero
    send_quat(8192, -8192, 8192, -8192);
    send_quat(1, 0, 0, 0);            // tiny, non-unit
  endtask

  task automatic send_random(int n);
    real c[4];
    real nrm;
    int q[4];
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 70) begin
        nrm = 0.0;
        for (int j = 0; j < 4; j++) begin
          c[j] = (real'($urandom_range(20000)) - 10000.0) / 10000.0;
          nrm += c[j] * c[j];
        end
        if (nrm < 1.0e-6) begin
          c[0] = 1.0;
          nrm = 1.0;
        end
        nrm = $sqrt(nrm);
        for (int j = 0; j < 4; j++) begin
          q[j] = $rtoi(c[j] / nrm * 16384.0);
          if ($urandom_range(9) == 0) q[j] += int'($urandom_range(8)) - 4;
        end
      end else begin
        for (int j = 0; j < 4; j++) q[j] = int'($urandom_range(65535)) - 32768;
      end
      send_quat(q[0], q[1], q[2], q[3]);
    end
  endtask

  task automatic test_random_phases();
    tx_idle_pct = 12;
    rx_idle_pct = 45;
    send_random(230);
    tx_idle_pct = 45;
    rx_idle_pct = 12;
    send_random(230);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random(240);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    tx_idle_pct = 12;
    rx_idle_pct = 45;
    test_extremes();
    test_special_angles();
    test_random_phases();
    in_valid <= 1'b0;
    while (expected_bins.size() != 0) @(posedge clk);
    // let the pipeline drain so stray beats show up
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_bins.size() == 0) begin
      $display("quaternion_to_binned_euler_unit test passed");
    end else begin
      $display("quaternion_to_binned_euler_unit test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("quaternion_to_binned_euler_unit test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/qbe_pkg.sv
rtl/qbe_isqrt_cell.sv
rtl/qbe_cordic_cell.sv
rtl/quaternion_to_binned_euler_unit.sv
dv/tb_top.sv
